// ===== src/emf_pkg.sv =====
package emf_pkg;

	// Register indexes of the write port
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_UNIT_FACTOR = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_NULL_CODE   = 1'b1;

	localparam logic [15:0] UNIT_FACTOR_RST = 16'd13400;
	localparam logic [15:0] NULL_CODE_RST   = 16'd65535;

	// Divider geometry: four lanes, 48-bit dividends, 34-bit divisors
	localparam int DIV_LANES = 4;
	localparam int DIV_NUM_W = 48;
	localparam int DIV_DEN_W = 34;
	localparam int DIV_TAG_W = 4;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SKIP  = 2'd1,
		ST_DEGEN = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	typedef struct packed {
		logic        sat;
		logic [31:0] val;
	} clamp_t;

	localparam logic signed [48:0] S32_MAX = 49'sd2147483647;
	localparam logic signed [48:0] S32_MIN = -49'sd2147483648;

	// Saturate a wide signed value to the signed 32-bit range
	function automatic clamp_t clamp_s32(input logic signed [48:0] v);
		clamp_t r;
		if (v > S32_MAX) begin
			r.sat = 1'b1;
			r.val = 32'h7fff_ffff;
		end else if (v < S32_MIN) begin
			r.sat = 1'b1;
			r.val = 32'h8000_0000;
		end else begin
			r.sat = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== src/emf_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, several lanes in step.
// The quotient bits shift into the dividend register as its bits are consumed.
module emf_div import emf_pkg::*; #(
	parameter int LN = DIV_LANES,
	parameter int NW = DIV_NUM_W,
	parameter int DW = DIV_DEN_W,
	parameter int TW = DIV_TAG_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [NW-1:0] num_in [LN],
	input  logic [DW-1:0] den_in [LN],
	input  logic [TW-1:0] tag_in,
	output logic [NW-1:0] quo [LN],
	output logic [TW-1:0] tag_out
);

	logic [NW-1:0] num_s [NW+1][LN];
	logic [DW-1:0] rem_s [NW][LN];
	logic [DW-1:0] den_s [NW][LN];
	logic [TW-1:0] tag_s [NW+1];

	// Stage zero is the incoming beat
	assign tag_s[0] = tag_in;
	for (genvar l = 0; l < LN; l++) begin : g_in
		assign num_s[0][l] = num_in[l];
		assign rem_s[0][l] = '0;
		assign den_s[0][l] = den_in[l];
		assign quo[l]      = num_s[NW][l];
	end
	assign tag_out = tag_s[NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		// Advance the tag with its beat
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k+1] <= '0;
			end else if (en) begin
				tag_s[k+1] <= tag_s[k];
			end
		end

		for (genvar l = 0; l < LN; l++) begin : g_lane
			logic [DW:0] trial;
			logic [DW:0] diff;
			logic        ge;

			// Try one subtract of the divisor
			always_comb begin
				trial = {rem_s[k][l], num_s[k][l][NW-1]};
				diff  = trial - {1'b0, den_s[k][l]};
				ge    = trial >= {1'b0, den_s[k][l]};
			end

			always_ff @(posedge clk) begin
				if (en) begin
					num_s[k+1][l] <= {num_s[k][l][NW-2:0], ge};
				end
			end

			// Carry remainder and divisor only to stages that still need them
			if (k < NW-1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[k+1][l] <= ge ? diff[DW-1:0] : trial[DW-1:0];
						den_s[k+1][l] <= den_s[k][l];
					end
				end
			end
		end
	end

endmodule

// ===== src/elastic_moduli_from_sonic.sv =====
// Channel   Handshake                 Beat
// input     in_valid / in_ready       p_slowness, s_slowness, density
// output    out_valid / out_ready     youngs_modulus, bulk_modulus, shear_modulus,
//                                     poisson_ratio, status
// config    wr_en (no wait)           wr_index, wr_data
//
// One sample per cycle is taken unless the output is held; the divider has 48 stages.
// The whole pipeline advances together; when the output beat is held, every stage
// holds and in_ready drops, so nothing is lost or repeated.
// Reset clears the valid bits and loads the register defaults; there is no clear pass.
module elastic_moduli_from_sonic import emf_pkg::*; #(
	parameter int NW = DIV_NUM_W,
	parameter int DW = DIV_DEN_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [15:0]          p_slowness,
	input  logic [15:0]          s_slowness,
	input  logic [15:0]          density,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   youngs_modulus,
	output logic signed [31:0]   bulk_modulus,
	output logic signed [31:0]   shear_modulus,
	output logic signed [31:0]   poisson_ratio,
	output logic [1:0]           status,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [15:0]          wr_data
);

	logic        adv;
	logic [15:0] unit_factor_q;
	logic [15:0] null_code_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_factor_q <= UNIT_FACTOR_RST;
			null_code_q   <= NULL_CODE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_UNIT_FACTOR: unit_factor_q <= wr_data;
				REG_NULL_CODE:   null_code_q   <= wr_data;
				default: ;
			endcase
		end
	end

	logic out_valid_q;
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// Stage 1: flags and squares
	logic        v_s1, skip_s1, degen_s1;
	logic [31:0] a_sq_s1, b_sq_s1, ud_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			skip_s1  <= (p_slowness == null_code_q) || (s_slowness == null_code_q)
				|| (density == null_code_q);
			degen_s1 <= (p_slowness == 16'd0) || (s_slowness == 16'd0)
				|| (p_slowness == s_slowness);
			a_sq_s1  <= 32'(p_slowness) * 32'(p_slowness);
			b_sq_s1  <= 32'(s_slowness) * 32'(s_slowness);
			ud_s1    <= 32'(unit_factor_q) * 32'(density);
		end
	end

	// Stage 2: dividends and divisors
	logic                v_s2, skip_s2, degen_s2, prneg_s2;
	logic [NW-1:0]       num_s2 [DIV_LANES];
	logic [DW-1:0]       den_s2 [DIV_LANES];
	logic signed [DW-1:0] dsa, nsa;
	logic [DW-1:0]       dsa_mag, nsa_mag, s_x3;

	always_comb begin
		s_x3    = {2'b00, b_sq_s1} + {1'b0, b_sq_s1, 1'b0};
		dsa     = $signed({2'b00, b_sq_s1}) - $signed({2'b00, a_sq_s1});
		nsa     = $signed({2'b00, b_sq_s1}) - $signed({1'b0, a_sq_s1, 1'b0});
		dsa_mag = dsa[DW-1] ? DW'(-dsa) : DW'(dsa);
		nsa_mag = nsa[DW-1] ? DW'(-nsa) : DW'(nsa);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			skip_s2   <= skip_s1;
			degen_s2  <= degen_s1;
			prneg_s2  <= dsa[DW-1] ^ nsa[DW-1];
			num_s2[0] <= NW'({ud_s1, 14'b0});
			num_s2[1] <= NW'({ud_s1, 14'b0});
			num_s2[2] <= NW'({ud_s1, 16'b0});
			num_s2[3] <= NW'({nsa_mag, 15'b0});
			den_s2[0] <= DW'(b_sq_s1);
			den_s2[1] <= DW'(a_sq_s1);
			den_s2[2] <= s_x3;
			den_s2[3] <= dsa_mag;
		end
	end

	// Divider: K/S, K/A, 4K/3S and the Poisson ratio magnitude
	logic [NW-1:0]        quo [DIV_LANES];
	logic [DIV_TAG_W-1:0] tag_div;

	emf_div #(
		.LN(DIV_LANES),
		.NW(NW),
		.DW(DW),
		.TW(DIV_TAG_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.num_in (num_s2),
		.den_in (den_s2),
		.tag_in ({v_s2, skip_s2, degen_s2, prneg_s2}),
		.quo    (quo),
		.tag_out(tag_div)
	);

	// Stage 3: signed forms
	logic                v_s3, skip_s3, degen_s3;
	logic signed [48:0]  shear_s3, bulk_s3, pr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= tag_div[3];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			skip_s3  <= tag_div[2];
			degen_s3 <= tag_div[1];
			shear_s3 <= $signed(49'(quo[0]));
			bulk_s3  <= $signed(49'(quo[1])) - $signed(49'(quo[2]));
			pr_s3    <= tag_div[0] ? -$signed(49'(quo[3])) : $signed(49'(quo[3]));
		end
	end

	// Stage 4: saturate
	logic                v_s4, skip_s4, degen_s4, sat_s4;
	logic signed [31:0]  n_s4, bulk_s4, p_s4;
	clamp_t              c_shear, c_bulk, c_pr;

	always_comb begin
		c_shear = clamp_s32(shear_s3);
		c_bulk  = clamp_s32(bulk_s3);
		c_pr    = clamp_s32(pr_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			skip_s4  <= skip_s3;
			degen_s4 <= degen_s3;
			sat_s4   <= c_shear.sat || c_bulk.sat || c_pr.sat;
			n_s4     <= $signed(c_shear.val);
			bulk_s4  <= $signed(c_bulk.val);
			p_s4     <= $signed(c_pr.val);
		end
	end

	// Stage 5: 1 + PR in 2^16 units
	logic                v_s5, skip_s5, degen_s5, sat_s5;
	logic signed [31:0]  n_s5, bulk_s5, p_s5;
	logic signed [32:0]  pf_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			skip_s5  <= skip_s4;
			degen_s5 <= degen_s4;
			sat_s5   <= sat_s4;
			n_s5     <= n_s4;
			bulk_s5  <= bulk_s4;
			p_s5     <= p_s4;
			pf_s5    <= 33'sd65536 + 33'(p_s4);
		end
	end

	// Stage 6: multiply N by (1 + PR)
	logic                v_s6, skip_s6, degen_s6, sat_s6;
	logic signed [31:0]  n_s6, bulk_s6, p_s6;
	logic signed [64:0]  prod_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			skip_s6  <= skip_s5;
			degen_s6 <= degen_s5;
			sat_s6   <= sat_s5;
			n_s6     <= n_s5;
			bulk_s6  <= bulk_s5;
			p_s6     <= p_s5;
			prod_s6  <= 65'(n_s5) * 65'(pf_s5);
		end
	end

	// Stage 7: divide by 2^15, truncating toward zero
	logic                v_s7, skip_s7, degen_s7, sat_s7;
	logic signed [31:0]  n_s7, bulk_s7, p_s7;
	logic signed [48:0]  ym_s7;
	logic signed [64:0]  prod_adj;

	assign prod_adj = prod_s6 + (prod_s6[64] ? 65'sd32767 : 65'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			skip_s7  <= skip_s6;
			degen_s7 <= degen_s6;
			sat_s7   <= sat_s6;
			n_s7     <= n_s6;
			bulk_s7  <= bulk_s6;
			p_s7     <= p_s6;
			ym_s7    <= $signed(prod_adj[63:15]);
		end
	end

	// Output register: saturate Young's modulus and drop the special cases to zero
	clamp_t             c_ym;
	logic               zero_out;
	logic signed [31:0] ym_q, bulk_q, shear_q, pr_q;
	status_t            status_q;

	assign c_ym     = clamp_s32(ym_s7);
	assign zero_out = skip_s7 || degen_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ym_q    <= zero_out ? 32'sd0 : $signed(c_ym.val);
			bulk_q  <= zero_out ? 32'sd0 : bulk_s7;
			shear_q <= zero_out ? 32'sd0 : n_s7;
			pr_q    <= zero_out ? 32'sd0 : p_s7;
			if (skip_s7) begin
				status_q <= ST_SKIP;
			end else if (degen_s7) begin
				status_q <= ST_DEGEN;
			end else if (sat_s7 || c_ym.sat) begin
				status_q <= ST_SAT;
			end else begin
				status_q <= ST_OK;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign youngs_modulus = ym_q;
	assign bulk_modulus   = bulk_q;
	assign shear_modulus  = shear_q;
	assign poisson_ratio  = pr_q;
	assign status         = status_q;

`ifndef ASSERT_OFF
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_SKIP) |-> (youngs_modulus == 32'sd0)
			&& (bulk_modulus == 32'sd0) && (shear_modulus == 32'sd0)
			&& (poisson_ratio == 32'sd0))
		else $error("skipped sample with non-zero moduli");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DEGEN) |-> (youngs_modulus == 32'sd0)
			&& (shear_modulus == 32'sd0) && (poisson_ratio == 32'sd0))
		else $error("degenerate sample with non-zero moduli");

	a_shear_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !shear_modulus[31])
		else $error("negative shear modulus");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output held");
`endif

endmodule

// ===== tb/tb_elastic_moduli_from_sonic.sv =====
module tb_elastic_moduli_from_sonic import emf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [15:0] p;
		logic [15:0] s;
		logic [15:0] d;
	} sample_t;

	typedef struct {
		logic signed [31:0] ym;
		logic signed [31:0] bulk;
		logic signed [31:0] shear;
		logic signed [31:0] pr;
		status_t            st;
	} moduli_t;

	localparam int PIPE_LAT = 56;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [15:0] p_slowness, s_slowness, density;
	logic signed [31:0] youngs_modulus, bulk_modulus, shear_modulus, poisson_ratio;
	logic [1:0] status;
	logic wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [15:0] wr_data;

	sample_t samples_pending[$];
	moduli_t moduli_expected[$];
	logic [15:0] unit_factor_q, null_code_q;
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int n_sat = 0;
	int n_skip = 0;
	int n_degen = 0;
	int gap_left, burst_left;

	elastic_moduli_from_sonic u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("TEST FAILED");
		$finish;
	end

	// Saturate to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fff_ffff;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Predict the moduli of one sample from the current register settings
	function automatic moduli_t predict_moduli(input sample_t smp);
		moduli_t r;
		longint unsigned sq_p, sq_s, k;
		longint shear, pr;
		bit sat;
		r = '{0, 0, 0, 0, ST_OK};
		sat = 1'b0;
		if (smp.p == null_code_q || smp.s == null_code_q || smp.d == null_code_q) begin
			r.st = ST_SKIP;
			return r;
		end
		if (smp.p == 0 || smp.s == 0 || smp.p == smp.s) begin
			r.st = ST_DEGEN;
			return r;
		end
		sq_p = longint'(smp.p) * smp.p;
		sq_s = longint'(smp.s) * smp.s;
		k = longint'(unit_factor_q) * smp.d * 16384;
		r.shear = sat32(longint'(k / sq_s), sat);
		r.bulk = sat32(longint'(k / sq_p) - longint'((4 * k) / (3 * sq_s)), sat);
		r.pr = sat32(((longint'(sq_s) - 2 * longint'(sq_p)) * 32768)
			/ (longint'(sq_s) - longint'(sq_p)), sat);
		shear = r.shear;
		pr = r.pr;
		r.ym = sat32((shear * (65536 + pr)) / 32768, sat);
		r.st = sat ? ST_SAT : ST_OK;
		return r;
	endfunction

	// Driver: bursts with random gaps, beat held until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			p_slowness <= '0;
			s_slowness <= '0;
			density <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				moduli_expected.push_back(predict_moduli('{p_slowness, s_slowness, density}));
				beats_in <= beats_in + 1;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (samples_pending.size() > 0) begin
					sample_t n;
					n = samples_pending.pop_front();
					in_valid <= 1'b1;
					p_slowness <= n.p;
					s_slowness <= n.s;
					density <= n.d;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 30);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each output beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				moduli_t e;
				beats_out <= beats_out + 1;
				if (moduli_expected.size() == 0) begin
					$error("output beat with no sample pending");
					errors++;
				end else begin
					e = moduli_expected.pop_front();
					if (youngs_modulus !== e.ym) begin
						$error("youngs_modulus exp %0d got %0d", e.ym, youngs_modulus);
						errors++;
					end
					if (bulk_modulus !== e.bulk) begin
						$error("bulk_modulus exp %0d got %0d", e.bulk, bulk_modulus);
						errors++;
					end
					if (shear_modulus !== e.shear) begin
						$error("shear_modulus exp %0d got %0d", e.shear, shear_modulus);
						errors++;
					end
					if (poisson_ratio !== e.pr) begin
						$error("poisson_ratio exp %0d got %0d", e.pr, poisson_ratio);
						errors++;
					end
					if (status !== e.st) begin
						$error("status exp %0d got %0d", e.st, status);
						errors++;
					end
					case (e.st)
						ST_SAT: n_sat++;
						ST_SKIP: n_skip++;
						ST_DEGEN: n_degen++;
						default: ;
					endcase
				end
			end
			// stall pattern: long open runs with occasional stalls
			out_ready <= (($urandom_range(0, 9) != 0) || (beats_out % 64 < 16));
		end
	end

	task automatic add_sample(input logic [15:0] p, input logic [15:0] s, input logic [15:0] d);
		samples_pending.push_back('{p, s, d});
	endtask

	// Random sample, mostly realistic slowness with pa < ps
	task automatic add_random(input int n);
		int kind;
		logic [15:0] p, s, d;
		repeat (n) begin
			kind = $urandom_range(0, 19);
			p = 16'($urandom_range(40 * 64, 200 * 64));
			s = p + 16'($urandom_range(1, 300 * 64));
			d = 16'($urandom_range(1 * 16384, 3 * 16384));
			if (kind == 0) p = null_code_q;
			else if (kind == 1) s = null_code_q;
			else if (kind == 2) d = null_code_q;
			else if (kind == 3) s = p;
			else if (kind < 8) begin
				p = 16'($urandom);
				s = 16'($urandom);
				d = 16'($urandom);
			end else if (kind == 8) begin
				p = 16'($urandom_range(1, 64));
				s = 16'($urandom_range(1, 64));
			end
			add_sample(p, s, d);
		end
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_UNIT_FACTOR) unit_factor_q = val;
		else null_code_q = val;
	endtask

	// Wait until every predicted beat has arrived, then let the pipe drain
	task automatic drain;
		int guard;
		guard = 0;
		while ((samples_pending.size() > 0 || in_valid || moduli_expected.size() > 0)
			&& guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	initial begin
		logic [15:0] uf_set[4];
		logic [15:0] nc_set[4];
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_UNIT_FACTOR;
		wr_data = '0;
		unit_factor_q = UNIT_FACTOR_RST;
		null_code_q = NULL_CODE_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, every status
		add_sample(16'd3200, 16'd6400, 16'd40960);
		add_sample(16'd65535, 16'd100, 16'd100);
		add_sample(16'd100, 16'd65535, 16'd100);
		add_sample(16'd100, 16'd200, 16'd65535);
		add_sample(16'd0, 16'd200, 16'd100);
		add_sample(16'd200, 16'd0, 16'd100);
		add_sample(16'd777, 16'd777, 16'd100);
		add_sample(16'd1, 16'd2, 16'd65534);
		add_sample(16'd1, 16'd65534, 16'd65534);
		add_sample(16'd65534, 16'd1, 16'd65534);
		add_sample(16'd65534, 16'd65533, 16'd0);
		add_sample(16'd2, 16'd3, 16'd1);
		add_sample(16'd5000, 16'd4000, 16'd30000);
		add_sample(16'h5555, 16'haaaa, 16'h5555);
		add_sample(16'haaaa, 16'h5555, 16'haaaa);
		add_random(200);
		drain();

		uf_set = '{16'd1, 16'd65535, 16'd1000, 16'd0};
		nc_set = '{16'd0, 16'd1234, 16'd65535, 16'd32768};
		for (int i = 0; i < 4; i++) begin
			write_reg(REG_UNIT_FACTOR, uf_set[i]);
			write_reg(REG_NULL_CODE, nc_set[i]);
			add_sample(nc_set[i], 16'd3000, 16'd3000);
			add_sample(16'd1, 16'd65535, 16'd65535);
			add_random(160);
			drain();
		end

		$display("Ran %0d samples over 5 register settings", beats_in);
		$display("  %0d saturated, %0d skipped, %0d degenerate", n_sat, n_skip, n_degen);
		if (errors == 0 && moduli_expected.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== sim.f =====
src/emf_pkg.sv
src/emf_div.sv
src/elastic_moduli_from_sonic.sv
tb/tb_elastic_moduli_from_sonic.sv
